/* hdl/bpcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcp_pkg - shared constants and types for the current predictor
// Field widths, register codes and reset values, the coefficient ROM and the
// exponent tables of the 23 polynomial terms.
// ----------------------------------------------------------------------------
package bpcp_pkg;

    localparam int COEF_WIDTH_DEF     = 32;
    localparam int NORM_FRAC_BITS_DEF = 20;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = 48;
    localparam int MEAN_SHIFT = 8;   // integer sample -> Q16.8
    localparam int INV_FRAC   = 24;  // reciprocal deviation is Q0.24
    localparam int COEF_FRAC  = 20;
    localparam int OUT_FRAC   = 16;
    localparam int MAX_DEG    = 6;
    localparam int NTERMS     = 23;
    localparam int TERM_W     = 48;  // terms stay far below 2^47 with the ROM values
    localparam int TREE_LEAVES = 32;
    localparam int SUM_W      = TERM_W + 5;
    localparam int Q_DEPTH    = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_TORQUE_MEAN    = 2'd0;
    localparam t_cfg_idx REG_TORQUE_INV_DEV = 2'd1;
    localparam t_cfg_idx REG_SPEED_MEAN     = 2'd2;
    localparam t_cfg_idx REG_SPEED_INV_DEV  = 2'd3;

    localparam logic [CFG_W-1:0] TORQUE_MEAN_RST    = 24'd18595;
    localparam logic [CFG_W-1:0] TORQUE_INV_DEV_RST = 24'd394525;
    localparam logic [CFG_W-1:0] SPEED_MEAN_RST     = 24'd120260;
    localparam logic [CFG_W-1:0] SPEED_INV_DEV_RST  = 24'd55901;

    // Q12.20 coefficients, order 1, x, y, x2, y2, xy, x3, y3, x2y, xy2, x4, y4,
    // x3y, x2y2, xy3, x5, y5, x4y, x3y2, x2y3, xy4, x6, y6
    localparam logic signed [47:0] COEF_ROM [NTERMS] = '{
        48'sd94275540,  48'sd56762719,  48'sd56890800,  48'sd3701134,
        -48'sd1460595,  48'sd32803333,  -48'sd314840,   48'sd1523747,
        48'sd2006694,   48'sd2331322,   -48'sd111302,   48'sd2746067,
        48'sd199220,    48'sd1215022,   48'sd1826794,   48'sd268205,
        48'sd200673,    -48'sd139284,   -48'sd63207,    48'sd472076,
        48'sd15707,     -48'sd69440,    -48'sd526602
    };

    localparam int EXP_X [NTERMS] = '{0,1,0,2,0,1,3,0,2,1,4,0,3,2,1,5,0,4,3,2,1,6,0};
    localparam int EXP_Y [NTERMS] = '{0,0,1,0,2,1,0,3,1,2,0,4,1,2,3,0,5,1,2,3,4,0,6};

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hdl/bpcp_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcp_ifs - sample and result channels
// Valid/ready channels carrying one sample pair and one prediction.
// ----------------------------------------------------------------------------
interface bpcp_in_if import bpcp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] torque_sample;
    logic signed [SAMPLE_W-1:0] speed_sample;

    modport source (output valid, output torque_sample, output speed_sample, input ready);
    modport sink   (input valid, input torque_sample, input speed_sample, output ready);
endinterface

interface bpcp_out_if import bpcp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] dc_current;
    logic                    saturated;

    modport source (output valid, output dc_current, output saturated, input ready);
    modport sink   (input valid, input dc_current, input saturated, output ready);
endinterface

/* hdl/bpcp_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcp_mul - two-stage signed multiplier with rounding shift
// Four half-width partial products, then sum, round half away from zero and
// arithmetic shift right by SH. Both registers advance only while i_en is high.
// ----------------------------------------------------------------------------
module bpcp_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 16,
    parameter int OW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [OW-1:0] o_p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PX = AW + BW + 1;

    logic signed [AL:0]         w_al;
    logic signed [AH-1:0]       w_ah;
    logic signed [BL:0]         w_bl;
    logic signed [BH-1:0]       w_bh;
    logic signed [AL+BL+1:0]    r_ll;
    logic signed [AL+BH:0]      r_lh;
    logic signed [AH+BL:0]      r_hl;
    logic signed [AH+BH-1:0]    r_hh;
    logic signed [PX-1:0]       w_sum;
    logic signed [PX-1:0]       w_rnd;
    logic signed [PX-1:0]       w_shr;
    logic signed [OW-1:0]       r_p;

    assign w_al = $signed({1'b0, i_a[AL-1:0]});
    assign w_ah = i_a[AW-1:AL];
    assign w_bl = $signed({1'b0, i_b[BL-1:0]});
    assign w_bh = i_b[BW-1:BL];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= w_al * w_bl;
            r_lh <= w_al * w_bh;
            r_hl <= w_ah * w_bl;
            r_hh <= w_ah * w_bh;
        end
    end

    // negative products take -1 so ties go away from zero
    assign w_sum = (PX'(r_hh) <<< (AL + BL)) + (PX'(r_hl) <<< AL)
                 + (PX'(r_lh) <<< BL) + PX'(r_ll);
    assign w_rnd = w_sum + (PX'(1) <<< (SH - 1)) - PX'(w_sum[PX-1]);
    assign w_shr = w_rnd >>> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_shr[OW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

/* hdl/bpcp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcp_queue - short FIFO between front and back
// Register-based ring buffer; head is visible while not empty.
// ----------------------------------------------------------------------------
module bpcp_queue import bpcp_pkg::*; #(
    parameter int W     = 49,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_status    o_status
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty) else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* hdl/bpcp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcp_front - sample intake and normalisation
// Accepts sample pairs, removes the mean, scales by the reciprocal deviation
// and clamps to Q4.F; pushes {flag, y, x} into the queue.
// ----------------------------------------------------------------------------
module bpcp_front import bpcp_pkg::*; #(
    parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bpcp_in_if.sink                         i_sample,
    input  logic [CFG_W-1:0]                i_torque_mean,
    input  logic [CFG_W-1:0]                i_torque_inv_dev,
    input  logic [CFG_W-1:0]                i_speed_mean,
    input  logic [CFG_W-1:0]                i_speed_inv_dev,
    input  t_q_status                       i_q_status,
    output logic                            o_push,
    output logic [2*(NORM_FRAC_BITS+4):0]   o_push_data
);
    localparam int NW     = NORM_FRAC_BITS + 4;
    localparam int DW     = SAMPLE_W + MEAN_SHIFT + 1;
    localparam int PRW    = DW + CFG_W + 1;
    localparam int RND_SH = MEAN_SHIFT + INV_FRAC - NORM_FRAC_BITS;
    localparam logic signed [PRW-1:0] V_MAX = (PRW'(8) <<< NORM_FRAC_BITS) - PRW'(1);
    localparam logic signed [PRW-1:0] V_MIN = -(PRW'(8) <<< NORM_FRAC_BITS);

    function automatic logic signed [DW-1:0] f_diff(
        input logic signed [SAMPLE_W-1:0] s,
        input logic        [CFG_W-1:0]    m
    );
        logic signed [SAMPLE_W+MEAN_SHIFT-1:0] v;
        v = {s, {MEAN_SHIFT{1'b0}}};
        return DW'(v) - DW'($signed(m));
    endfunction

    // returns {clamped, value}
    function automatic logic [NW:0] f_norm(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] q;
        logic signed [PRW-1:0] r;
        logic signed [NW-1:0]  v;
        logic                  sat;
        q = p + (PRW'(1) <<< (RND_SH - 1)) - PRW'(p[PRW-1]);
        r = q >>> RND_SH;
        priority if (r > V_MAX) begin
            v   = V_MAX[NW-1:0];
            sat = 1'b1;
        end else if (r < V_MIN) begin
            v   = V_MIN[NW-1:0];
            sat = 1'b1;
        end else begin
            v   = r[NW-1:0];
            sat = 1'b0;
        end
        return {sat, v};
    endfunction

    logic                  w_en;
    logic                  r_f1_vld, r_f2_vld;
    logic signed [DW-1:0]  r_dt, r_ds;
    logic signed [PRW-1:0] r_pt, r_ps;
    logic [NW:0]           w_nt, w_ns;

    // stall only when the last stage holds an item the queue cannot take
    assign w_en           = !(r_f2_vld && i_q_status.full);
    assign i_sample.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= i_sample.valid;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dt <= f_diff(i_sample.torque_sample, i_torque_mean);
            r_ds <= f_diff(i_sample.speed_sample, i_speed_mean);
            r_pt <= r_dt * $signed({1'b0, i_torque_inv_dev});
            r_ps <= r_ds * $signed({1'b0, i_speed_inv_dev});
        end
    end

    assign w_nt        = f_norm(r_pt);
    assign w_ns        = f_norm(r_ps);
    assign o_push      = r_f2_vld && w_en;
    assign o_push_data = {w_nt[NW] | w_ns[NW], w_ns[NW-1:0], w_nt[NW-1:0]};

endmodule

/* hdl/bpcp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcp_back - polynomial evaluation pipeline
// Power chains, mixed monomials, coefficient products, adder tree and output
// clamp, all advancing together under one stall enable.
// ----------------------------------------------------------------------------
module bpcp_back import bpcp_pkg::*; #(
    parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
    parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_q_status                     i_q_status,
    input  logic [2*(NORM_FRAC_BITS+4):0] i_q_data,
    output logic                          o_pop,
    bpcp_out_if.source                    o_result
);
    localparam int NW     = NORM_FRAC_BITS + 4;
    localparam int PW     = NORM_FRAC_BITS + 20;   // holds up to 8^6
    localparam int T_POW  = 2 * (MAX_DEG - 1);     // last power ready
    localparam int T_MONO = T_POW + 2;
    localparam int T_TERM = T_MONO + 2;
    localparam int T_OUT  = T_TERM + 6;            // five tree levels, then clamp
    localparam int DLY    = T_MONO;
    localparam int L1     = TREE_LEAVES / 2;
    localparam int L2     = TREE_LEAVES / 4;
    localparam int L3     = TREE_LEAVES / 8;
    localparam int L4     = TREE_LEAVES / 16;
    localparam logic signed [SUM_W-1:0] O_MAX = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] O_MIN = -(SUM_W'(1) <<< (OUT_W - 1));

    logic                   w_en;
    logic [T_OUT:0]         r_vld;
    logic [T_OUT-1:0]       r_flg;
    logic signed [NW-1:0]   r_n1 [2];
    logic signed [PW-1:0]   w_pw [2][1:MAX_DEG];
    logic signed [PW-1:0]   r_pd [2][1:MAX_DEG][1:DLY];
    logic signed [PW-1:0]   w_mono [NTERMS];
    logic signed [TERM_W-1:0] w_term [NTERMS];
    logic signed [SUM_W-1:0] w_leaf [TREE_LEAVES];
    logic signed [SUM_W-1:0] r_t1 [L1];
    logic signed [SUM_W-1:0] r_t2 [L2];
    logic signed [SUM_W-1:0] r_t3 [L3];
    logic signed [SUM_W-1:0] r_t4 [L4];
    logic signed [SUM_W-1:0] r_t5;
    logic signed [OUT_W-1:0] r_out, n_out;
    logic                    r_sat, n_sat;

    assign w_en  = !r_vld[T_OUT] || o_result.ready;
    assign o_pop = w_en && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[T_OUT-1:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flg   <= {r_flg[T_OUT-2:0], i_q_data[2*NW]};
            r_n1[0] <= i_q_data[NW-1:0];
            r_n1[1] <= i_q_data[2*NW-1:NW];
            for (int ax = 0; ax < 2; ax++) begin
                for (int k = 1; k <= MAX_DEG; k++) begin
                    r_pd[ax][k][1] <= w_pw[ax][k];
                    for (int d = 2; d <= DLY; d++) begin
                        r_pd[ax][k][d] <= r_pd[ax][k][d-1];
                    end
                end
            end
        end
    end

    // each chain step multiplies the previous power by the base, delayed to match after the first step
    for (genvar g_ax = 0; g_ax < 2; g_ax++) begin : g_axis
        assign w_pw[g_ax][1] = PW'(r_n1[g_ax]);
        for (genvar g_k = 2; g_k <= MAX_DEG; g_k++) begin : g_pow
            logic signed [PW-1:0] w_base;
            if (g_k == 2) begin : g_first
                assign w_base = w_pw[g_ax][1];
            end else begin : g_later
                assign w_base = r_pd[g_ax][1][2*(g_k-2)];
            end
            bpcp_mul #(.AW(PW), .BW(PW), .SH(NORM_FRAC_BITS), .OW(PW)) u_pow (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (w_pw[g_ax][g_k-1]),
                .i_b   (w_base),
                .o_p   (w_pw[g_ax][g_k])
            );
        end
    end

    for (genvar g_i = 0; g_i < NTERMS; g_i++) begin : g_term
        localparam int EX = EXP_X[g_i];
        localparam int EY = EXP_Y[g_i];
        logic signed [COEF_WIDTH-1:0] w_coef;

        if (EX > 0 && EY > 0) begin : g_mixed
            bpcp_mul #(.AW(PW), .BW(PW), .SH(NORM_FRAC_BITS), .OW(PW)) u_mono (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_a   (r_pd[0][EX][T_POW+2-2*EX]),
                .i_b   (r_pd[1][EY][T_POW+2-2*EY]),
                .o_p   (w_mono[g_i])
            );
        end else if (EX == 0 && EY == 0) begin : g_const
            assign w_mono[g_i] = PW'(1) <<< NORM_FRAC_BITS;
        end else if (EX > 0) begin : g_pure_x
            assign w_mono[g_i] = r_pd[0][EX][T_MONO+2-2*EX];
        end else begin : g_pure_y
            assign w_mono[g_i] = r_pd[1][EY][T_MONO+2-2*EY];
        end

        // narrow coefficient widths wrap, two's complement
        assign w_coef = COEF_ROM[g_i][COEF_WIDTH-1:0];

        bpcp_mul #(
            .AW (COEF_WIDTH),
            .BW (PW),
            .SH (NORM_FRAC_BITS + COEF_FRAC - OUT_FRAC),
            .OW (TERM_W)
        ) u_coef (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_coef),
            .i_b   (w_mono[g_i]),
            .o_p   (w_term[g_i])
        );
    end

    for (genvar g_l = 0; g_l < TREE_LEAVES; g_l++) begin : g_leaf
        if (g_l < NTERMS) begin : g_used
            assign w_leaf[g_l] = SUM_W'(w_term[g_l]);
        end else begin : g_pad
            assign w_leaf[g_l] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < L1; j++) r_t1[j] <= w_leaf[2*j] + w_leaf[2*j+1];
            for (int j = 0; j < L2; j++) r_t2[j] <= r_t1[2*j] + r_t1[2*j+1];
            for (int j = 0; j < L3; j++) r_t3[j] <= r_t2[2*j] + r_t2[2*j+1];
            for (int j = 0; j < L4; j++) r_t4[j] <= r_t3[2*j] + r_t3[2*j+1];
            r_t5 <= r_t4[0] + r_t4[1];
        end
    end

    always_comb begin
        priority if (r_t5 > O_MAX) begin
            n_out = O_MAX[OUT_W-1:0];
            n_sat = 1'b1;
        end else if (r_t5 < O_MIN) begin
            n_out = O_MIN[OUT_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_out = r_t5[OUT_W-1:0];
            n_sat = r_flg[T_OUT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    assign o_result.valid      = r_vld[T_OUT];
    assign o_result.dc_current = r_out;
    assign o_result.saturated  = r_sat;

`ifndef SYNTHESIS
    a_pop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0]) else $error("popped transaction did not enter pipeline");
`endif

endmodule

/* hdl/bivariate_poly_current_predictor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bivariate_poly_current_predictor - DC current from torque and speed
// Normalises a torque/speed pair and evaluates a fixed 23-term polynomial.
//
// Usage:
//  - i_sample carries one transaction per (torque, speed) pair, signed ints;
//    o_result returns one transaction per pair: Q32.16 current plus a flag
//    set when normalisation or the final sum was clamped.
//  - Registers (means Q16.8, reciprocal deviations Q0.24) are written through
//    i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while no
//    transaction is in flight, as the block itself does not enforce this.
//  - Throughput: one pair per cycle while o_result.ready is high; every
//    stage of the multiplier pipeline is fully pipelined, so nothing iterates.
//  - Front (2 stages), the 4-entry queue and back
//    (21 stages). When a result waits and o_result.ready is low the whole
//    back pipeline freezes; the queue then fills and the front drops
//    i_sample.ready.
//  - Synchronous active-low reset clears all valid bits, empties the queue
//    and restores the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module bivariate_poly_current_predictor import bpcp_pkg::*; #(
    parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
    parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bpcp_in_if.sink          i_sample,
    bpcp_out_if.source       o_result,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    localparam int NW = NORM_FRAC_BITS + 4;
    localparam int QW = 2 * NW + 1;   // {flag, y, x}

    logic [CFG_W-1:0] r_torque_mean, r_torque_inv_dev;
    logic [CFG_W-1:0] r_speed_mean, r_speed_inv_dev;
    logic             w_push, w_pop;
    logic [QW-1:0]    w_push_data, w_q_data;
    t_q_status        w_q_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_torque_mean    <= TORQUE_MEAN_RST;
            r_torque_inv_dev <= TORQUE_INV_DEV_RST;
            r_speed_mean     <= SPEED_MEAN_RST;
            r_speed_inv_dev  <= SPEED_INV_DEV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TORQUE_MEAN:    r_torque_mean    <= i_cfg_data;
                REG_TORQUE_INV_DEV: r_torque_inv_dev <= i_cfg_data;
                REG_SPEED_MEAN:     r_speed_mean     <= i_cfg_data;
                REG_SPEED_INV_DEV:  r_speed_inv_dev  <= i_cfg_data;
            endcase
        end
    end

    // front: mean removal, scaling, clamp to Q4.F
    bpcp_front #(.NORM_FRAC_BITS(NORM_FRAC_BITS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (i_sample),
        .i_torque_mean    (r_torque_mean),
        .i_torque_inv_dev (r_torque_inv_dev),
        .i_speed_mean     (r_speed_mean),
        .i_speed_inv_dev  (r_speed_inv_dev),
        .i_q_status       (w_q_status),
        .o_push           (w_push),
        .o_push_data      (w_push_data)
    );

    // decoupling queue
    bpcp_queue #(.W(QW), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_data   (w_q_data),
        .o_status (w_q_status)
    );

    // back: powers, monomials, coefficient products, sum and clamp
    bpcp_back #(
        .COEF_WIDTH     (COEF_WIDTH),
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_q_data   (w_q_data),
        .o_pop      (w_pop),
        .o_result   (o_result)
    );

endmodule
